// ===== rtl/tcw_pkg.sv =====
// shared constants and types for the text console writer
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  // first cell of the bottom row, also the number of cells a scroll moves
  localparam int LAST_ROW_START = CELLS - COLUMNS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] DEFAULT_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_READ = 2'd1,
    OP_SET  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } wr_port_t;

endpackage

// ===== rtl/tcw_screen_ram.sv =====
// screen cell store: one write port, one registered read port
module tcw_screen_ram (
  input  logic                     clk,
  input  tcw_pkg::wr_port_t        wr,
  input  logic [tcw_pkg::ADDR_W-1:0] raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/text_console_writer_top.sv =====
// text console writer: sequencer, cursor logic and screen store
// throughput: one transaction at a time; scroll time is set by the single write port of
//   the store, one cell moved per cycle
// reset: synchronous; a clearing pass blanks every cell, in_ready low
module text_console_writer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]  character,
  input  logic [tcw_pkg::CHAR_W-1:0]  attribute,
  input  logic [tcw_pkg::POS_W-1:0]   position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::POS_W-1:0]   cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]  cell_data,
  output logic                        scrolled
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_FILL,
    ST_RD_ADDR,
    ST_RD_TAKE,
    ST_DIV,
    ST_RESP
  } state_t;

  state_t state;

  // cursor kept with its column so row starts need no division
  logic [tcw_pkg::CNT_W-1:0]  cursor;
  logic [tcw_pkg::COL_W-1:0]  col;

  // captured transaction
  logic [tcw_pkg::CHAR_W-1:0] ch;
  logic [tcw_pkg::CHAR_W-1:0] attr_hi;
  logic [tcw_pkg::CNT_W-1:0]  pos_c;

  // sweep counter shared by clear, scroll copy and bottom row fill
  logic [tcw_pkg::CNT_W-1:0]  idx;
  logic                       copy_pend;
  logic [tcw_pkg::ADDR_W-1:0] copy_dst;

  // remainder for the iterative column search on set cursor
  logic [tcw_pkg::CNT_W-1:0]  rem;

  logic [tcw_pkg::CELL_W-1:0] data_r;
  logic                       scr_r;

  tcw_pkg::wr_port_t          wr;
  logic [tcw_pkg::ADDR_W-1:0] raddr;
  logic [tcw_pkg::CELL_W-1:0] rdata;

  tcw_screen_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // position clamped to the last cell
  logic [tcw_pkg::WIDE_W-1:0] pos_wide;
  logic [tcw_pkg::CNT_W-1:0]  pos_clamp;

  assign pos_wide  = tcw_pkg::WIDE_W'(position);
  assign pos_clamp = (pos_wide >= tcw_pkg::WIDE_W'(tcw_pkg::CELLS)) ?
                     tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1) : tcw_pkg::CNT_W'(pos_wide);

  // put decision, evaluated in the put state
  logic [tcw_pkg::CNT_W-1:0]  row_start;
  logic [tcw_pkg::CNT_W-1:0]  cursor_dec;
  logic [tcw_pkg::CNT_W-1:0]  cursor_inc;
  logic [tcw_pkg::CNT_W-1:0]  cursor_n;
  logic [tcw_pkg::COL_W-1:0]  col_n;
  logic                       scroll_n;
  logic                       put_we;
  logic [tcw_pkg::ADDR_W-1:0] put_addr;
  logic [tcw_pkg::CELL_W-1:0] put_data;

  assign row_start  = cursor - tcw_pkg::CNT_W'(col);
  assign cursor_dec = cursor - tcw_pkg::CNT_W'(1);
  assign cursor_inc = cursor + tcw_pkg::CNT_W'(1);

  always_comb begin
    cursor_n = cursor;
    col_n    = col;
    scroll_n = 1'b0;
    put_we   = 1'b0;
    put_addr = cursor[tcw_pkg::ADDR_W-1:0];
    put_data = {attr_hi, ch};
    case (ch)
      tcw_pkg::CH_BS: begin
        // backspace at the home cell does nothing
        if (cursor != '0) begin
          cursor_n = cursor_dec;
          col_n    = (col == '0) ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) :
                     col - tcw_pkg::COL_W'(1);
          put_we   = 1'b1;
          put_addr = cursor_dec[tcw_pkg::ADDR_W-1:0];
          put_data = {attr_hi, tcw_pkg::CH_SPACE};
        end
      end
      tcw_pkg::CH_LF: begin
        col_n = '0;
        if (row_start == tcw_pkg::CNT_W'(tcw_pkg::LAST_ROW_START)) begin
          scroll_n = 1'b1;
          cursor_n = row_start;
        end else begin
          cursor_n = row_start + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
        end
      end
      tcw_pkg::CH_CR: begin
        col_n    = '0;
        cursor_n = row_start;
      end
      default: begin
        put_we = 1'b1;
        if (col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
          col_n = '0;
          if (cursor == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
            // wrapped past the last cell: land on the bottom row after scrolling
            scroll_n = 1'b1;
            cursor_n = tcw_pkg::CNT_W'(tcw_pkg::LAST_ROW_START);
          end else begin
            cursor_n = cursor_inc;
          end
        end else begin
          col_n    = col + tcw_pkg::COL_W'(1);
          cursor_n = cursor_inc;
        end
      end
    endcase
  end

  // scroll source is one row below the destination
  logic [tcw_pkg::CNT_W-1:0] src;
  assign src = idx + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);

  // store port steering
  always_comb begin
    wr.we   = 1'b0;
    wr.addr = idx[tcw_pkg::ADDR_W-1:0];
    wr.data = tcw_pkg::BLANK_CELL;
    raddr   = pos_c[tcw_pkg::ADDR_W-1:0];
    case (state)
      ST_PUT: begin
        wr.we   = put_we;
        wr.addr = put_addr;
        wr.data = put_data;
      end
      ST_SCROLL: begin
        // read one cell ahead, write the cell fetched the cycle before
        wr.we   = copy_pend;
        wr.addr = copy_dst;
        wr.data = rdata;
        raddr   = src[tcw_pkg::ADDR_W-1:0];
      end
      ST_FILL, ST_CLEAR: begin
        wr.we = 1'b1;
      end
      default: begin
        wr.we = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      cursor    <= '0;
      col       <= '0;
      copy_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // the response state sets or holds the output itself
      if (out_valid && out_ready && state != ST_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (idx == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + tcw_pkg::CNT_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            ch      <= character;
            attr_hi <= (attribute == '0) ? tcw_pkg::DEFAULT_ATTR : attribute;
            pos_c   <= pos_clamp;
            data_r  <= '0;
            scr_r   <= 1'b0;
            case (tcw_pkg::opcode_t'(opcode))
              tcw_pkg::OP_PUT:  state <= ST_PUT;
              tcw_pkg::OP_READ: state <= ST_RD_ADDR;
              tcw_pkg::OP_SET: begin
                cursor <= pos_clamp;
                rem    <= pos_clamp;
                state  <= ST_DIV;
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_PUT: begin
          cursor <= cursor_n;
          col    <= col_n;
          scr_r  <= scroll_n;
          if (scroll_n) begin
            idx       <= '0;
            copy_pend <= 1'b0;
            state     <= ST_SCROLL;
          end else begin
            state <= ST_RESP;
          end
        end
        ST_SCROLL: begin
          if (idx < tcw_pkg::CNT_W'(tcw_pkg::LAST_ROW_START)) begin
            copy_pend <= 1'b1;
            copy_dst  <= idx[tcw_pkg::ADDR_W-1:0];
            idx       <= idx + tcw_pkg::CNT_W'(1);
          end else begin
            // drain the last pending copy, then blank the bottom row
            copy_pend <= 1'b0;
            if (!copy_pend) begin
              state <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          if (idx == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
            state <= ST_RESP;
          end else begin
            idx <= idx + tcw_pkg::CNT_W'(1);
          end
        end
        ST_RD_ADDR: begin
          state <= ST_RD_TAKE;
        end
        ST_RD_TAKE: begin
          data_r <= rdata;
          state  <= ST_RESP;
        end
        ST_DIV: begin
          // one row subtracted per cycle until the column remains
          if (rem >= tcw_pkg::CNT_W'(tcw_pkg::COLUMNS)) begin
            rem <= rem - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
          end else begin
            col   <= rem[tcw_pkg::COL_W-1:0];
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            cursor_position <= tcw_pkg::POS_W'(cursor);
            cell_data       <= data_r;
            scrolled        <= scr_r;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tcw_checker.sv =====
// port-level assertions for the text console writer, bound to the top level
module tcw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tcw_pkg::POS_W-1:0]  cursor_position,
  input logic [tcw_pkg::CELL_W-1:0] cell_data,
  input logic                       scrolled
);

  // clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready during clearing pass");

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_position < tcw_pkg::POS_W'(tcw_pkg::CELLS)))
    else $error("cursor beyond screen");

  // a scroll only comes from a put and leaves the cursor on the bottom row
  a_scroll_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |->
      (cell_data == '0 && cursor_position >= tcw_pkg::POS_W'(tcw_pkg::LAST_ROW_START)))
    else $error("bad scroll result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(cursor_position) && $stable(cell_data) && $stable(scrolled)))
    else $error("result changed while stalled");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .cursor_position (cursor_position),
  .cell_data       (cell_data),
  .scrolled        (scrolled)
);
